// ----- rtl/core/audio_es_to_pes_packetizer_assert.svh -----
// Assertion macros used by the packetizer queue.
`ifndef AUDIO_ES_TO_PES_PACKETIZER_ASSERT_SVH
`define AUDIO_ES_TO_PES_PACKETIZER_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define AEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aep assertion failed");

// Condition in this cycle implies a consequence in the next cycle.
`define AEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aep assertion failed");

`endif

// ----- rtl/core/aep_pkg.sv -----
package aep_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [16:0] PTS_CLOCK_HZ = 17'd90000;

    // configuration register indexes
    localparam logic [2:0] REG_SPF   = 3'd0;
    localparam logic [2:0] REG_RATE  = 3'd1;
    localparam logic [2:0] REG_FRAME = 3'd2;
    localparam logic [2:0] REG_FADE  = 3'd3;
    localparam logic [2:0] REG_START = 3'd4;
    localparam logic [2:0] REG_STOP  = 3'd5;
    localparam logic [2:0] REG_SID   = 3'd6;

    // stream format latched on the first frame
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_MPEG = 2'd1;
    localparam logic [1:0] FMT_DTS  = 2'd2;
    localparam logic [1:0] FMT_AC3  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_SYNC_LOST = 2'd1;
    localparam logic [1:0] ST_PTS_LIMIT = 2'd2;

    // command kinds between front and back
    localparam logic [1:0] CMD_PASS = 2'd0;
    localparam logic [1:0] CMD_HDR  = 2'd1;
    localparam logic [1:0] CMD_STAT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;    // pass-through byte
        logic        done;    // frame closes on the last data beat
        logic        halt2;   // append a PTS-limit beat
        logic [1:0]  stat;    // status for CMD_STAT
        logic [32:0] ts;
        logic [15:0] len;
        logic        ad;
        logic [7:0]  fade;
        logic [7:0]  sid;
        logic [31:0] held;    // held[7:0] is the first frame byte
    } t_cmd;

endpackage

// ----- rtl/core/audio_es_to_pes_packetizer.sv -----
// Payload bytes: one beat accepted per cycle while the command queue is not full; each
// is queued, then registered for output. Fourth byte of each frame: input stalls while
// the multiply and the 62-step restoring divider compute the next PTS; header beats follow.
// Output runs one beat per cycle via the single output register while the receiver is ready.
// Reset (synchronous, active low) restores register defaults and clears all control state.
module audio_es_to_pes_packetizer import aep_pkg::*; #(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_es_valid,
    output logic        o_es_ready,
    input  logic [7:0]  i_es_byte,
    output logic        o_pes_valid,
    input  logic        i_pes_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data
);

    // front: classify each input beat into a command (pass byte, header, status)
    // queue: short command buffer so front and back stall independently
    // back: expand each command into output beats

    logic q_push, q_pop, q_full, q_empty;
    t_cmd q_in, q_out;

    aep_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_es_valid  (i_es_valid),
        .o_es_ready  (o_es_ready),
        .i_es_byte   (i_es_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    aep_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    aep_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (q_out),
        .o_q_pop      (q_pop),
        .o_pes_valid  (o_pes_valid),
        .i_pes_ready  (i_pes_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_status     (o_status)
    );

endmodule

// ----- rtl/core/aep_front.sv -----
module aep_front import aep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_es_valid,
    output logic        o_es_ready,
    input  logic [7:0]  i_es_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [12:0] r_spf;
    logic [17:0] r_rate;
    logic [15:0] r_frame;
    logic [8:0]  r_fade;
    logic [32:0] r_start;
    logic [32:0] r_stop;
    logic [7:0]  r_sid;

    logic [2:0]  r_state;
    logic [1:0]  r_fmt;
    logic        r_first;
    logic [7:0]  r_held [4];
    logic [16:0] r_bp;
    logic [2:0]  r_pad;
    logic [31:0] r_fc;
    logic [32:0] r_cur;
    logic        r_halted;
    logic [1:0]  r_hcode;

    logic [44:0] r_p1;
    logic [39:0] r_plo;
    logic [38:0] r_phi;
    logic [61:0] r_dvd;
    logic [17:0] r_rem;
    logic [5:0]  r_cnt;

    logic [15:0] eff;
    logic [17:0] divisor;
    logic        accept;
    logic        adv;
    logic [16:0] n_bp;
    logic [2:0]  n_pad;
    logic        pass_done;
    logic        pass_halt;
    logic        mp, ac, dts, ok;
    logic [1:0]  fmt_now;
    logic [18:0] trial;
    logic        ge;
    logic [18:0] diff;
    logic [32:0] n_cur;
    logic        hdr_done;
    logic        ad;
    logic [2:0]  hdr_pad;

    assign eff      = (r_frame < 16'd4) ? 16'd4 : r_frame;
    assign divisor  = (r_rate == 18'd0) ? 18'd1 : r_rate;
    assign ad       = !r_fade[8];
    assign o_cfg_ready = 1'b1;
    assign o_es_ready  = (r_state == S_IDLE) && !i_q_full;
    assign accept      = i_es_valid && o_es_ready;

    // payload byte bookkeeping
    assign adv       = (r_bp < {1'b0, eff}) || (r_pad == 3'd0);
    assign n_bp      = adv ? r_bp + 17'd1 : r_bp;
    assign n_pad     = adv ? r_pad : r_pad - 3'd1;
    assign pass_done = (n_bp >= {1'b0, eff}) && (n_pad == 3'd0);
    assign pass_halt = pass_done && (r_stop != 33'd0) && (r_cur >= r_stop);

    // sync classification on the fourth byte (held bytes 0..2 plus the incoming one)
    assign mp  = (r_held[0] == 8'hFF) && (r_held[1][7:5] == 3'b111);
    assign ac  = (r_held[0] == 8'h0B) && (r_held[1] == 8'h77);
    assign dts = (r_held[0] == 8'h7F) && (r_held[1] == 8'hFE) && (r_held[2] == 8'h80)
                 && (i_es_byte == 8'h01);
    assign fmt_now = r_first ? r_fmt : (dts ? FMT_DTS : (mp ? FMT_MPEG : FMT_AC3));
    assign ok = ((fmt_now == FMT_MPEG) && mp) || ((fmt_now != FMT_MPEG) && ac)
                || ((fmt_now == FMT_DTS) && dts);
    assign hdr_pad = ((fmt_now == FMT_MPEG) && r_held[2][1])
                     ? ((r_held[1][2:1] == 2'b11) ? 3'd4 : 3'd1) : 3'd0;

    // restoring divider, one quotient bit a cycle
    assign trial = {r_rem, r_dvd[61]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    assign n_cur    = 33'(r_start + r_dvd[32:0]);
    assign hdr_done = (eff == 16'd4) && (r_pad == 3'd0);

    always_comb begin
        o_q_push = 1'b0;
        o_q_cmd  = '0;
        o_q_cmd.ts   = r_cur;
        o_q_cmd.ad   = ad;
        o_q_cmd.fade = r_fade[7:0];
        o_q_cmd.sid  = r_sid;
        o_q_cmd.len  = eff + (ad ? 16'd25 : 16'd8) + {13'd0, r_pad};
        o_q_cmd.held = {r_held[3], r_held[2], r_held[1], r_held[0]};
        if (r_state == S_PUSH) begin
            o_q_push       = !i_q_full;
            o_q_cmd.kind   = CMD_HDR;
            o_q_cmd.done   = hdr_done;
            o_q_cmd.halt2  = hdr_done && (r_stop != 33'd0) && (n_cur >= r_stop);
        end else if (accept) begin
            if (r_halted) begin
                o_q_push     = 1'b1;
                o_q_cmd.kind = CMD_STAT;
                o_q_cmd.stat = r_hcode;
            end else if (r_bp >= 17'd4) begin
                o_q_push      = 1'b1;
                o_q_cmd.kind  = CMD_PASS;
                o_q_cmd.data  = i_es_byte;
                o_q_cmd.done  = pass_done;
                o_q_cmd.halt2 = pass_halt;
            end else if ((r_bp == 17'd3) && !ok) begin
                o_q_push     = 1'b1;
                o_q_cmd.kind = CMD_STAT;
                o_q_cmd.stat = ST_SYNC_LOST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spf    <= 13'd1152;
            r_rate   <= 18'd48000;
            r_frame  <= 16'd768;
            r_fade   <= 9'h1FF;
            r_start  <= '0;
            r_stop   <= '0;
            r_sid    <= 8'd192;
            r_state  <= S_IDLE;
            r_fmt    <= '0;
            r_first  <= 1'b0;
            r_bp     <= '0;
            r_pad    <= '0;
            r_fc     <= 32'd1;
            r_cur    <= '0;
            r_halted <= 1'b0;
            r_hcode  <= ST_DATA;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SPF:   r_spf   <= i_cfg_data[12:0];
                    REG_RATE:  r_rate  <= i_cfg_data[17:0];
                    REG_FRAME: r_frame <= i_cfg_data[15:0];
                    REG_FADE:  r_fade  <= i_cfg_data[8:0];
                    REG_START: begin
                        r_start <= i_cfg_data;
                        if (!r_first) begin
                            r_cur <= i_cfg_data;
                        end
                    end
                    REG_STOP:  r_stop  <= i_cfg_data;
                    REG_SID:   r_sid   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && !r_halted) begin
                        if (r_bp >= 17'd4) begin
                            r_pad <= n_pad;
                            r_bp  <= pass_done ? 17'd0 : n_bp;
                            if (pass_halt) begin
                                r_halted <= 1'b1;
                                r_hcode  <= ST_PTS_LIMIT;
                            end
                        end else begin
                            r_held[r_bp[1:0]] <= i_es_byte;
                            r_bp <= r_bp + 17'd1;
                            if (r_bp == 17'd3) begin
                                r_fmt   <= fmt_now;
                                r_first <= 1'b1;
                                if (!ok) begin
                                    r_halted <= 1'b1;
                                    r_hcode  <= ST_SYNC_LOST;
                                end else begin
                                    r_pad   <= hdr_pad;
                                    r_state <= S_MUL1;
                                end
                            end
                        end
                    end
                end
                S_MUL1: begin
                    r_p1    <= 45'(r_fc) * 45'(r_spf);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_plo   <= 40'(r_p1[22:0]) * 40'(PTS_CLOCK_HZ);
                    r_phi   <= 39'(r_p1[44:23]) * 39'(PTS_CLOCK_HZ);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_dvd   <= 62'(r_plo) + {r_phi, 23'd0};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= ge ? diff[17:0] : trial[17:0];
                    r_dvd <= {r_dvd[60:0], ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd61) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_cur   <= n_cur;
                        r_fc    <= r_fc + 32'd1;
                        r_state <= S_IDLE;
                        if (hdr_done) begin
                            r_bp <= '0;
                            if ((r_stop != 33'd0) && (n_cur >= r_stop)) begin
                                r_halted <= 1'b1;
                                r_hcode  <= ST_PTS_LIMIT;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/aep_queue.sv -----
`include "audio_es_to_pes_packetizer_assert.svh"
module aep_queue import aep_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `AEP_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)
    `AEP_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, o_empty, !i_pop)
    `AEP_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_push && !i_pop, !o_empty)

endmodule

// ----- rtl/core/aep_back.sv -----
module aep_back import aep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_pes_valid,
    input  logic       i_pes_ready,
    output logic [7:0] o_out_byte,
    output logic       o_packet_end,
    output logic [1:0] o_status
);

    logic [5:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic [1:0] r_stat;

    logic [5:0] last_data;
    logic [5:0] last;
    logic       emit;
    logic [7:0] b;
    logic       e;
    logic [1:0] s;

    function automatic logic [7:0] hdr_byte(input logic [5:0] k, input t_cmd c);
        logic [5:0] j;
        logic [5:0] hk;
        logic [7:0] v;
        j  = k - 6'd14;
        hk = k - (c.ad ? 6'd31 : 6'd14);
        v  = 8'h00;
        if (k < 6'd14) begin
            case (k)
                6'd0:    v = 8'h00;
                6'd1:    v = 8'h00;
                6'd2:    v = 8'h01;
                6'd3:    v = c.sid;
                6'd4:    v = c.len[15:8];
                6'd5:    v = c.len[7:0];
                6'd6:    v = 8'h81;
                6'd7:    v = c.ad ? 8'h81 : 8'h80;
                6'd8:    v = c.ad ? 8'h16 : 8'h05;
                6'd9:    v = {4'b0010, c.ts[32:30], 1'b1};
                6'd10:   v = c.ts[29:22];
                6'd11:   v = {c.ts[21:15], 1'b1};
                6'd12:   v = c.ts[14:7];
                default: v = {c.ts[6:0], 1'b1};
            endcase
        end else if (c.ad && (k < 6'd31)) begin
            case (j)
                6'd0:    v = 8'h8E;
                6'd1:    v = 8'hF8;
                6'd2:    v = 8'h44;
                6'd3:    v = 8'h54;
                6'd4:    v = 8'h47;
                6'd5:    v = 8'h41;
                6'd6:    v = 8'h44;
                6'd7:    v = 8'h31;
                6'd8:    v = c.fade;
                6'd9:    v = 8'h00;
                default: v = 8'hFF;
            endcase
        end else begin
            case (hk[1:0])
                2'd0:    v = c.held[7:0];
                2'd1:    v = c.held[15:8];
                2'd2:    v = c.held[23:16];
                default: v = c.held[31:24];
            endcase
        end
        return v;
    endfunction

    assign last_data = (i_q_cmd.kind == CMD_HDR) ? (i_q_cmd.ad ? 6'd34 : 6'd17) : 6'd0;
    assign last      = last_data + {5'd0, (i_q_cmd.kind != CMD_STAT) && i_q_cmd.halt2};
    assign emit      = !i_q_empty && (!r_valid || i_pes_ready);
    assign o_q_pop   = emit && (r_idx == last);

    always_comb begin
        b = 8'h00;
        e = 1'b0;
        s = ST_DATA;
        if (i_q_cmd.kind == CMD_STAT) begin
            s = i_q_cmd.stat;
        end else if (r_idx > last_data) begin
            s = ST_PTS_LIMIT;
        end else if (i_q_cmd.kind == CMD_PASS) begin
            b = i_q_cmd.data;
            e = i_q_cmd.done;
        end else begin
            b = hdr_byte(r_idx, i_q_cmd);
            e = (r_idx == last_data) && i_q_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= b;
            r_end  <= e;
            r_stat <= s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_idx   <= (r_idx == last) ? 6'd0 : r_idx + 6'd1;
            end else if (i_pes_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_pes_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_packet_end = r_end;
    assign o_status     = r_stat;

endmodule

// ----- tb/sv/audio_es_to_pes_packetizer_tb.sv -----
`timescale 1ns / 100ps

module audio_es_to_pes_packetizer_tb import aep_pkg::*;;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 120;
    localparam logic [32:0] PTS_MAX     = 33'h1_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } t_pes_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_es_valid = 1'b0;
    logic        o_es_ready;
    logic [7:0]  i_es_byte = 8'd0;
    logic        o_pes_valid;
    logic        i_pes_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_packet_end;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [32:0] i_cfg_data = 33'd0;

    audio_es_to_pes_packetizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_es_valid   (i_es_valid),
        .o_es_ready   (o_es_ready),
        .i_es_byte    (i_es_byte),
        .o_pes_valid  (o_pes_valid),
        .i_pes_ready  (i_pes_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Packetizer shadow: registers and most state mirrored at the block widths
    // ------------------------------------------------------------------
    logic [12:0] spf_q;
    logic [17:0] rate_q;
    logic [15:0] frame_q;
    logic [8:0]  fade_q;
    logic [32:0] pts_from_q;
    logic [32:0] pts_stop_q;
    logic [7:0]  sid_q;

    logic [1:0]  fmt_q;
    logic        seen_q;
    logic [7:0]  held_q [4];
    int unsigned pos_q;
    int unsigned pad_q;
    logic [31:0] fcount_q;
    logic [32:0] pts_q;
    logic        halted_q;
    logic [1:0]  halt_code_q;

    t_pes_beat   pes_expected [$];
    int          errors = 0;
    bit          no_gaps = 1'b0;    // burst mode: no idling on either side
    int          hold_len = 0;      // long receiver hold-off, counted by the receiver
    int          rx_gap = 0;        // short receiver idle run, counted by the receiver
    longint      cycles = 0;

    function automatic int unsigned eff_frame();
        return (frame_q < 16'd4) ? 4 : int'(frame_q);
    endfunction

    function automatic void push_beat(logic [7:0] d, logic e, logic [1:0] s);
        pes_expected.push_back('{data: d, last: e, status: s});
    endfunction

    function automatic void shadow_reset();
        spf_q = 13'd1152;
        rate_q = 18'd48000;
        frame_q = 16'd768;
        fade_q = 9'h1FF;
        pts_from_q = '0;
        pts_stop_q = '0;
        sid_q = 8'd192;
        fmt_q = FMT_NONE;
        seen_q = 1'b0;
        pos_q = 0;
        pad_q = 0;
        fcount_q = 32'd1;
        pts_q = '0;
        halted_q = 1'b0;
        halt_code_q = ST_DATA;
    endfunction

    function automatic void shadow_config(logic [2:0] idx, logic [32:0] val);
        case (idx)
            REG_SPF:   spf_q = val[12:0];
            REG_RATE:  rate_q = val[17:0];
            REG_FRAME: frame_q = val[15:0];
            REG_FADE:  fade_q = val[8:0];
            REG_START: begin
                pts_from_q = val;
                if (!seen_q) pts_q = val;
            end
            REG_STOP:  pts_stop_q = val;
            REG_SID:   sid_q = val[7:0];
            default: ;
        endcase
    endfunction

    // Emit the byte just passed; close a complete frame and flag a reached PTS stop
    function automatic void close_or_pass(logic [7:0] b);
        bit done;
        done = (pos_q >= eff_frame()) && (pad_q == 0);
        push_beat(b, done, ST_DATA);
        if (done) begin
            pos_q = 0;
            if (pts_stop_q != 0 && pts_q >= pts_stop_q) begin
                halted_q = 1'b1;
                halt_code_q = ST_PTS_LIMIT;
                push_beat(8'd0, 1'b0, ST_PTS_LIMIT);
            end
        end
    endfunction

    function automatic void predict_pes(logic [7:0] b);
        bit mp, ac, dts, ad;
        logic [15:0] len;
        logic [32:0] ts;
        longint unsigned q, div;
        logic [7:0] adx [8];
        if (halted_q) begin
            push_beat(8'd0, 1'b0, halt_code_q);
            return;
        end
        if (pos_q >= 4) begin
            if (pos_q < eff_frame() || pad_q == 0) pos_q++;
            else pad_q--;
            close_or_pass(b);
            return;
        end
        held_q[pos_q] = b;
        pos_q++;
        if (pos_q < 4) return;

        mp = held_q[0] == 8'hFF && held_q[1][7:5] == 3'b111;
        ac = held_q[0] == 8'h0B && held_q[1] == 8'h77;
        dts = held_q[0] == 8'h7F && held_q[1] == 8'hFE && held_q[2] == 8'h80 &&
              held_q[3] == 8'h01;
        if (!seen_q) begin
            fmt_q = dts ? FMT_DTS : (mp ? FMT_MPEG : FMT_AC3);
            seen_q = 1'b1;
        end
        if (!((fmt_q == FMT_MPEG && mp) || (fmt_q != FMT_MPEG && ac) ||
              (fmt_q == FMT_DTS && dts))) begin
            halted_q = 1'b1;
            halt_code_q = ST_SYNC_LOST;
            push_beat(8'd0, 1'b0, ST_SYNC_LOST);
            return;
        end
        pad_q = 0;
        if (fmt_q == FMT_MPEG && held_q[2][1])
            pad_q = (held_q[1][2:1] == 2'b11) ? 4 : 1;
        ad = !fade_q[8];
        len = 16'(eff_frame() + (ad ? 25 : 8) + pad_q);
        ts = pts_q;

        push_beat(8'h00, 1'b0, ST_DATA);
        push_beat(8'h00, 1'b0, ST_DATA);
        push_beat(8'h01, 1'b0, ST_DATA);
        push_beat(sid_q, 1'b0, ST_DATA);
        push_beat(len[15:8], 1'b0, ST_DATA);
        push_beat(len[7:0], 1'b0, ST_DATA);
        push_beat(8'h81, 1'b0, ST_DATA);
        push_beat(ad ? 8'h81 : 8'h80, 1'b0, ST_DATA);
        push_beat(ad ? 8'h16 : 8'h05, 1'b0, ST_DATA);
        push_beat({4'b0010, ts[32:30], 1'b1}, 1'b0, ST_DATA);
        push_beat(ts[29:22], 1'b0, ST_DATA);
        push_beat({ts[21:15], 1'b1}, 1'b0, ST_DATA);
        push_beat(ts[14:7], 1'b0, ST_DATA);
        push_beat({ts[6:0], 1'b1}, 1'b0, ST_DATA);
        if (ad) begin
            adx = '{8'h8E, 8'hF8, 8'h44, 8'h54, 8'h47, 8'h41, 8'h44, 8'h31};
            foreach (adx[i]) push_beat(adx[i], 1'b0, ST_DATA);
            push_beat(fade_q[7:0], 1'b0, ST_DATA);
            push_beat(8'h00, 1'b0, ST_DATA);
            repeat (7) push_beat(8'hFF, 1'b0, ST_DATA);
        end

        // next PTS: start + frames * samples * 90 kHz / rate, wrapped at 33 bits
        div = (rate_q == 0) ? 1 : longint'(rate_q);
        q = (longint'(fcount_q) * longint'(spf_q) * 64'd90000) / div;
        pts_q = 33'((longint'(pts_from_q) + q) & 64'h1_FFFF_FFFF);
        fcount_q++;

        push_beat(held_q[0], 1'b0, ST_DATA);
        push_beat(held_q[1], 1'b0, ST_DATA);
        push_beat(held_q[2], 1'b0, ST_DATA);
        close_or_pass(held_q[3]);
    endfunction

    // ------------------------------------------------------------------
    // Idling, drivers and receiver
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one ES byte; leave valid high after the beat so back-to-back is legal
    task automatic send_es_byte(logic [7:0] b);
        int g;
        g = pick_gap();
        @(negedge i_clk);
        if (g > 0) begin
            i_es_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_es_valid <= 1'b1;
        i_es_byte <= b;
        do @(posedge i_clk); while (!o_es_ready);
        predict_pes(b);
    endtask

    task automatic stop_es();
        @(negedge i_clk);
        i_es_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [32:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_config(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain: wait for every expected beat, then cover the header divide latency
    task automatic wait_drained();
        stop_es();
        while (pes_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_all(logic [12:0] spf, logic [17:0] rate, logic [15:0] fb,
                             logic [8:0] fade, logic [32:0] from, logic [32:0] stop,
                             logic [7:0] sid);
        write_reg(REG_SPF, 33'(spf));
        write_reg(REG_RATE, 33'(rate));
        write_reg(REG_FRAME, 33'(fb));
        write_reg(REG_FADE, 33'(fade));
        write_reg(REG_START, from);
        write_reg(REG_STOP, stop);
        write_reg(REG_SID, 33'(sid));
    endtask

    // Build a sync header for the latched format; pad selects MPEG padding
    function automatic void make_sync(logic [1:0] f, int pad_kind, output logic [7:0] h [4]);
        logic [7:0] b1, b2;
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        case (f)
            FMT_MPEG: begin
                b1[7:5] = 3'b111;
                b2[1] = (pad_kind != 0);
                if (pad_kind == 4) b1[2:1] = 2'b11;
                else if (pad_kind == 1 && b1[2:1] == 2'b11) b1[2:1] = 2'b10;
                h = '{8'hFF, b1, b2, 8'($urandom)};
            end
            FMT_DTS: begin
                if ($urandom_range(3) == 0) h = '{8'h0B, 8'h77, b1, b2};
                else h = '{8'h7F, 8'hFE, 8'h80, 8'h01};
            end
            default: h = '{8'h0B, 8'h77, b1, b2};
        endcase
    endfunction

    // Send one whole frame, payload either random or a fixed fill value
    task automatic send_frame(int pad_kind, bit fill_on, logic [7:0] fill);
        logic [7:0] h [4];
        int unsigned extra;
        make_sync(fmt_q == FMT_NONE ? FMT_MPEG : fmt_q, pad_kind, h);
        extra = 0;
        if (fmt_q == FMT_MPEG && h[2][1]) extra = (h[1][2:1] == 2'b11) ? 4 : 1;
        foreach (h[i]) send_es_byte(h[i]);
        repeat (eff_frame() - 4 + extra) send_es_byte(fill_on ? fill : 8'($urandom));
    endtask

    // Receiver: ready for one cycle, then idle for a random run
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pes_ready <= 1'b0;
        end else if (hold_len > 0) begin
            i_pes_ready <= 1'b0;
            hold_len--;
        end else if (rx_gap > 0) begin
            i_pes_ready <= 1'b0;
            rx_gap--;
        end else begin
            i_pes_ready <= 1'b1;
            rx_gap = pick_gap();
        end
    end

    // Compare each PES beat against the oldest expectation
    always @(posedge i_clk) begin
        t_pes_beat exp_beat;
        if (i_rst_n && o_pes_valid && i_pes_ready) begin
            if (pes_expected.size() == 0) begin
                $display("%0t: unexpected beat: actual byte %h end %b status %0d",
                         $time, o_out_byte, o_packet_end, o_status);
                errors++;
            end else begin
                exp_beat = pes_expected.pop_front();
                if (o_out_byte !== exp_beat.data) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, exp_beat.data, o_out_byte);
                    errors++;
                end
                if (o_packet_end !== exp_beat.last) begin
                    $display("%0t: packet_end expected %b actual %b",
                             $time, exp_beat.last, o_packet_end);
                    errors++;
                end
                if (o_status !== exp_beat.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_beat.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Latch the stream format on the first frame, with pts_start reloading the PTS
    task automatic test_first_frame();
        logic [1:0] f;
        f = 2'($urandom_range(1, 3));
        write_all(13'd8191, 18'd1, 16'd2, 9'h1FF, PTS_MAX, 33'd0, 8'd0);
        fmt_q = f;    // steer the first header only; the shadow relatches it
        send_frame(0, 1'b1, 8'h00);
        wait_drained();
        send_frame(0, 1'b1, 8'hFF);
        wait_drained();
    endtask

    // Padding, AD extension and the remaining register extremes
    task automatic test_directed();
        write_all(13'd1, 18'd192000, 16'd6, 9'd255, 33'd0, 33'd0, 8'd255);
        send_frame(4, 1'b1, 8'hA5);
        send_frame(1, 1'b1, 8'h5A);
        wait_drained();
        write_all(13'd1152, 18'd0, 16'd4, 9'd0, 33'd12345, 33'd0, 8'd192);
        send_frame(0, 1'b0, 8'h00);
        send_frame(1, 1'b0, 8'h00);
        wait_drained();
    endtask

    // Random settings per phase, short frames mostly, a few longer ones
    task automatic test_random_frames();
        int sent;
        int phase_bytes;
        logic [8:0] fade;
        sent = 0;
        while (sent < 240) begin
            no_gaps = ($urandom_range(4) == 0);
            fade = ($urandom_range(1) == 0) ? 9'h1FF : 9'($urandom_range(255));
            write_all(13'($urandom_range(1, 8191)), 18'($urandom_range(1, 192000)),
                      ($urandom_range(9) == 0) ? 16'($urandom_range(100, 300))
                                               : 16'($urandom_range(4, 40)),
                      fade, {1'($urandom), 32'($urandom)}, 33'd0,
                      8'($urandom));
            phase_bytes = 0;
            while (phase_bytes < 80) begin
                send_frame($urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 4 : 1),
                           1'b0, 8'h00);
                phase_bytes += eff_frame() + 4;
            end
            sent += phase_bytes;
            wait_drained();
        end
        no_gaps = 1'b0;
    endtask

    // Hold the receiver off for a long stretch so the block fills and stalls input
    task automatic test_backpressure();
        write_reg(REG_FRAME, 33'd60);
        @(posedge i_clk);
        hold_len = 400;
        no_gaps = 1'b1;
        send_frame(0, 1'b0, 8'h00);
        send_frame(0, 1'b0, 8'h00);
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // End with either the PTS limit or a sync loss, then check the halt status sticks
    task automatic test_halt();
        write_all(13'd1152, 18'd48000, 16'd8, 9'h1FF, 33'd0, 33'd0, 8'd192);
        if ($urandom_range(1) == 0) begin
            write_reg(REG_STOP, 33'd1);
            repeat (3) send_frame(0, 1'b0, 8'h00);
        end else begin
            send_frame(0, 1'b0, 8'h00);
            repeat (4) send_es_byte(8'h00);
        end
        repeat (6) send_es_byte(8'($urandom));
        wait_drained();
    endtask

    initial begin
        shadow_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DRAIN_WAIT) @(posedge i_clk);

        test_first_frame();
        test_directed();
        test_random_frames();
        test_backpressure();
        test_halt();

        if (errors == 0 && pes_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
